/* src/cpu_alu_bcd_flags_macros.svh */
`ifndef CPU_ALU_BCD_FLAGS_MACROS_SVH
`define CPU_ALU_BCD_FLAGS_MACROS_SVH

// antecedent holds now, consequent holds in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent holds now, consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cab_pkg.sv */
package cab_pkg;

	typedef enum logic [5:0] {
		CMD_ADD8  = 6'd0,  CMD_ADC8  = 6'd1,  CMD_SUB8  = 6'd2,  CMD_SBC8  = 6'd3,
		CMD_AND8  = 6'd4,  CMD_OR8   = 6'd5,  CMD_XOR8  = 6'd6,  CMD_CP8   = 6'd7,
		CMD_BIT8  = 6'd8,  CMD_INC8  = 6'd9,  CMD_DEC8  = 6'd10, CMD_CPL8  = 6'd11,
		CMD_NEG8  = 6'd12, CMD_MLT   = 6'd13, CMD_DIV   = 6'd14, CMD_ADD16 = 6'd15,
		CMD_ADC16 = 6'd16, CMD_SUB16 = 6'd17, CMD_SBC16 = 6'd18, CMD_CP16  = 6'd19,
		CMD_INC16 = 6'd20, CMD_DEC16 = 6'd21, CMD_RL    = 6'd22, CMD_RLC   = 6'd23,
		CMD_RR    = 6'd24, CMD_RRC   = 6'd25, CMD_SLA   = 6'd26, CMD_SLL   = 6'd27,
		CMD_SRA   = 6'd28, CMD_SRL   = 6'd29, CMD_SWAP  = 6'd30, CMD_PACK  = 6'd31,
		CMD_UPCK  = 6'd32, CMD_SEP   = 6'd33
	} cmd_t;

	localparam logic [5:0] BCD_DIGIT_MAX = 6'h09;
	localparam logic [9:0] BCD_BYTE_MAX  = 10'h099;
	localparam logic [9:0] BCD_LO_ADJ    = 10'h006;
	localparam logic [9:0] BCD_HI_ADJ    = 10'h060;

	typedef struct packed {
		logic [5:0]  cmd;
		logic [15:0] a;
		logic [15:0] b;
		logic        c;
		logic        z;
		logic        v;
		logic        n;
		logic        dec;
		logic        unp;
	} in_t;

	typedef struct packed {
		logic [15:0] r;
		logic        c;
		logic        z;
		logic        v;
		logic        n;
		logic        wr;
		logic        fault;
	} res_t;

	typedef struct packed {
		logic        is_div;
		logic [7:0]  d;
		logic [7:0]  rem;
		logic [15:0] work;
	} div_t;

endpackage

/* src/cpu_alu_bcd_flags.sv */
// An accepted request is registered at stage 1, moves through stages 2 to 4 and lands in the output register.
// Throughput: one request per cycle; all stages advance together, held by output stall.
// The 16/8 divide runs four restoring steps in each of stages 2 to 5.
// Reset (arst_n low, asynchronous) clears all stage valid bits; payload is not reset.
module cpu_alu_bcd_flags (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  cmd,
	input  logic [15:0] operand_a,
	input  logic [15:0] operand_b,
	input  logic        carry_in,
	input  logic        zero_in,
	input  logic        overflow_in,
	input  logic        negative_in,
	input  logic        decimal_mode,
	input  logic        unpack_mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_value,
	output logic        carry_out,
	output logic        zero_out,
	output logic        overflow_out,
	output logic        negative_out,
	output logic        divide_fault,
	output logic        result_written
);
	import cab_pkg::*;

	function automatic res_t add8(logic [7:0] a8, logic [7:0] b8, logic ci, logic dec,
			logic unp, res_t base);
		logic [7:0] t;
		logic [7:0] s;
		logic [4:0] cv;
		logic [5:0] h;
		logic [9:0] o;
		res_t f;
		f  = base;
		t  = unp ? {a8[3:0], 4'h0} : a8;
		s  = unp ? {b8[3:0], 4'h0} : b8;
		cv = unp ? {ci, 4'h0} : {4'h0, ci};
		o  = {2'b00, t} + {2'b00, s} + {5'b0, cv};
		h  = {2'b00, t[3:0]} + {2'b00, s[3:0]} + {1'b0, cv};
		if (dec) begin
			if (h > BCD_DIGIT_MAX) o = o + BCD_LO_ADJ;
			if (o > BCD_BYTE_MAX) o = o + BCD_HI_ADJ;
			f.v = 1'b0;
			f.n = 1'b0;
		end else begin
			f.v = (t[7] ~^ s[7]) & (t[7] ^ o[7]);
			f.n = o[7];
		end
		f.c = |o[9:8];
		f.z = (o[7:0] == 8'h00);
		f.r = unp ? {12'h000, o[7:4]} : {8'h00, o[7:0]};
		add8 = f;
	endfunction

	function automatic res_t sub8(logic [7:0] a8, logic [7:0] b8, logic ci, logic dec,
			logic unp, res_t base);
		logic [7:0] t;
		logic [7:0] s;
		logic [4:0] cv;
		logic signed [10:0] h;
		logic signed [10:0] o;
		res_t f;
		f  = base;
		t  = unp ? {a8[3:0], 4'h0} : a8;
		s  = unp ? {b8[3:0], 4'h0} : b8;
		cv = unp ? {ci, 4'h0} : {4'h0, ci};
		o  = $signed({3'b000, t}) - $signed({3'b000, s}) - $signed({6'b0, cv});
		h  = $signed({7'b0, t[3:0]}) - $signed({7'b0, s[3:0]}) - $signed({6'b0, cv});
		if (dec) begin
			if (h < 0) o = o - $signed({1'b0, BCD_LO_ADJ});
			if (o < 0) o = o - $signed({1'b0, BCD_HI_ADJ});
			f.v = 1'b0;
			f.n = 1'b0;
		end else begin
			f.v = (t[7] ^ s[7]) & (t[7] ^ o[7]);
			f.n = t[7];
		end
		f.c = o[10];
		f.z = (o[7:0] == 8'h00);
		f.r = unp ? {12'h000, o[7:4]} : {8'h00, o[7:0]};
		sub8 = f;
	endfunction

	function automatic div_t div_step4(div_t x);
		logic [8:0] tmp;
		div_t y;
		y = x;
		for (int i = 0; i < 4; i++) begin
			tmp = {y.rem, y.work[15]};
			y.work = {y.work[14:0], 1'b0};
			if (tmp >= {1'b0, y.d}) begin
				tmp = tmp - {1'b0, y.d};
				y.work[0] = 1'b1;
			end
			y.rem = tmp[7:0];
		end
		div_step4 = y;
	endfunction

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	in_t  in_s1;
	res_t res_s2, res_s3, res_s4;
	div_t div_s2, div_s3, div_s4;
	logic [15:0] a_s2, a_s3, a_s4;
	res_t res_d, fin_d;
	div_t div_d, div_last;

	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			out_valid <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1  <= '{cmd, operand_a, operand_b, carry_in, zero_in, overflow_in,
				negative_in, decimal_mode, unpack_mode};
			res_s2 <= res_d;
			div_s2 <= div_step4(div_d);
			a_s2   <= in_s1.a;
			res_s3 <= res_s2;
			div_s3 <= div_step4(div_s2);
			a_s3   <= a_s2;
			res_s4 <= res_s3;
			div_s4 <= div_step4(div_s3);
			a_s4   <= a_s3;
			{result_value, carry_out, zero_out, overflow_out, negative_out,
				result_written, divide_fault} <= fin_d;
		end
	end

	always_comb begin
		logic [7:0] a8;
		logic [7:0] b8;
		logic [7:0] r8;
		logic [16:0] o17;
		res_t base;
		res_t tmp;
		a8   = in_s1.a[7:0];
		b8   = in_s1.b[7:0];
		base = '{16'h0000, in_s1.c, in_s1.z, in_s1.v, in_s1.n, 1'b1, 1'b0};
		res_d = base;
		r8   = 8'h00;
		o17  = 17'h0;
		tmp  = base;
		div_d = '{1'b0, b8, 8'h00, in_s1.a};
		unique case (in_s1.cmd)
			CMD_ADD8: res_d = add8(a8, b8, 1'b0, in_s1.dec, in_s1.unp, base);
			CMD_ADC8: res_d = add8(a8, b8, in_s1.c, in_s1.dec, in_s1.unp, base);
			CMD_SUB8: res_d = sub8(a8, b8, 1'b0, in_s1.dec, in_s1.unp, base);
			CMD_SBC8: res_d = sub8(a8, b8, in_s1.c, in_s1.dec, in_s1.unp, base);
			CMD_AND8, CMD_OR8, CMD_XOR8, CMD_CPL8: begin
				priority case (in_s1.cmd)
					CMD_AND8: r8 = a8 & b8;
					CMD_OR8:  r8 = a8 | b8;
					CMD_XOR8: r8 = a8 ^ b8;
					default:  r8 = ~a8;
				endcase
				res_d.r = {8'h00, r8};
				res_d.z = (r8 == 8'h00);
				res_d.n = r8[7];
			end
			CMD_CP8: begin
				tmp = sub8(a8, b8, 1'b0, 1'b0, 1'b0, base);
				res_d = tmp;
				res_d.n = tmp.r[7];
				res_d.r = 16'h0000;
				res_d.wr = 1'b0;
			end
			CMD_BIT8: begin
				r8 = a8 & b8;
				res_d.z = (r8 == 8'h00);
				res_d.n = r8[7];
				res_d.wr = 1'b0;
			end
			CMD_INC8, CMD_DEC8: begin
				r8 = (in_s1.cmd == CMD_INC8) ? a8 + 8'd1 : a8 - 8'd1;
				res_d.r = {8'h00, r8};
				res_d.z = (r8 == 8'h00);
			end
			CMD_NEG8: res_d = sub8(8'h00, a8, 1'b0, in_s1.dec, in_s1.unp, base);
			CMD_MLT: begin
				res_d.r = {8'h00, a8} * {8'h00, b8};
				res_d.z = (res_d.r == 16'h0000);
				res_d.c = 1'b0;
				res_d.v = 1'b0;
				res_d.n = res_d.r[15];
			end
			CMD_DIV: begin
				res_d.r = in_s1.a;
				res_d.wr = 1'b0;
				res_d.fault = (b8 == 8'h00);
				div_d.is_div = (b8 != 8'h00);
			end
			CMD_ADD16, CMD_ADC16: begin
				o17 = {1'b0, in_s1.a} + {1'b0, in_s1.b}
					+ {16'h0, (in_s1.cmd == CMD_ADC16) & in_s1.c};
				res_d.r = o17[15:0];
				res_d.v = (in_s1.a[15] ~^ in_s1.b[15]) & (in_s1.a[15] ^ o17[15]);
				res_d.c = o17[16];
				res_d.n = o17[15];
				res_d.z = (o17[15:0] == 16'h0000);
			end
			CMD_SUB16, CMD_SBC16, CMD_CP16: begin
				o17 = {1'b0, in_s1.a} - {1'b0, in_s1.b}
					- {16'h0, (in_s1.cmd == CMD_SBC16) & in_s1.c};
				res_d.r = (in_s1.cmd == CMD_CP16) ? 16'h0000 : o17[15:0];
				res_d.wr = (in_s1.cmd != CMD_CP16);
				res_d.v = (in_s1.a[15] ^ in_s1.b[15]) & (in_s1.a[15] ^ o17[15]);
				res_d.c = o17[16];
				res_d.n = o17[15];
				res_d.z = (o17[15:0] == 16'h0000);
			end
			CMD_INC16, CMD_DEC16: begin
				res_d.r = (in_s1.cmd == CMD_INC16) ? in_s1.a + 16'd1 : in_s1.a - 16'd1;
				res_d.z = (res_d.r == 16'h0000);
			end
			CMD_RL, CMD_RLC, CMD_RR, CMD_RRC, CMD_SLA, CMD_SLL, CMD_SRA, CMD_SRL: begin
				priority case (in_s1.cmd)
					CMD_RL:  r8 = {a8[6:0], in_s1.c};
					CMD_RLC: r8 = {a8[6:0], a8[7]};
					CMD_RR:  r8 = {in_s1.c, a8[7:1]};
					CMD_RRC: r8 = {a8[0], a8[7:1]};
					CMD_SLA, CMD_SLL: r8 = {a8[6:0], 1'b0};
					CMD_SRA: r8 = {a8[7], a8[7:1]};
					default: r8 = {1'b0, a8[7:1]};
				endcase
				res_d.r = {8'h00, r8};
				res_d.z = (r8 == 8'h00);
				res_d.n = r8[7];
				res_d.c = (in_s1.cmd == CMD_RL || in_s1.cmd == CMD_RLC
					|| in_s1.cmd == CMD_SLA || in_s1.cmd == CMD_SLL) ? a8[7] : a8[0];
				if (in_s1.cmd == CMD_SLA) res_d.v = a8[7] ^ r8[7];
				if (in_s1.cmd == CMD_SRA) res_d.v = 1'b0;
			end
			CMD_SWAP: res_d.r = {8'h00, a8[3:0], a8[7:4]};
			CMD_PACK: res_d.r = {8'h00, b8[3:0], a8[3:0]};
			CMD_UPCK: res_d.r = {4'h0, a8[7:4], 4'h0, a8[3:0]};
			CMD_SEP:  res_d.r = {8'h00, {8{a8[7]}}};
			default: begin
				res_d.r = 16'h0000;
				res_d.wr = 1'b0;
			end
		endcase
	end

	always_comb begin
		div_last = div_step4(div_s4);
		fin_d = res_s4;
		if (div_s4.is_div) begin
			fin_d.c = 1'b0;
			if (div_last.work[15:8] != 8'h00) begin
				fin_d.r  = a_s4;
				fin_d.n  = 1'b1;
				fin_d.v  = 1'b1;
				fin_d.wr = 1'b0;
			end else begin
				fin_d.r  = {div_last.rem, div_last.work[7:0]};
				fin_d.n  = div_last.work[7];
				fin_d.z  = (div_last.work[7:0] == 8'h00);
				fin_d.v  = 1'b0;
				fin_d.wr = 1'b1;
			end
		end
	end

endmodule

/* src/cab_checker.sv */
`include "cpu_alu_bcd_flags_macros.svh"

module cab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] result_value,
	input logic        divide_fault,
	input logic        result_written
);
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(result_value), "result changed under stall")
	`ASSERT_IMPLY(a_fault_nowr, clk, arst_n, out_valid && divide_fault, !result_written, "fault result written")
	`ASSERT_IMPLY(a_ready_free, clk, arst_n, !out_valid || out_ready, in_ready, "input stalled without back pressure")
endmodule

bind cpu_alu_bcd_flags cab_checker u_cab_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.result_value(result_value),
	.divide_fault(divide_fault),
	.result_written(result_written)
);
